### rtl/core/prpe_pkg.sv
// ----------------------------------------------------------------------------
// prpe_pkg
// shared constants, types and helpers of the planar pose engine
// ----------------------------------------------------------------------------
package prpe_pkg;

    localparam int CordicSteps = 24;

    localparam logic signed [31:0] PiQ28     = 32'sd843314857;
    localparam logic signed [31:0] TwoPiQ28  = 32'sd1686629713;
    localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
    localparam logic signed [31:0] OneQ30    = 32'sd1073741824;
    localparam logic signed [31:0] GainQ30   = 32'sd652032874;

    typedef enum logic [1:0] {
        CMD_COMPOSE  = 2'd0,
        CMD_RELATIVE = 2'd1,
        CMD_POINT    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    // item fields carried along the pipeline
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [32:0] px;      // position operand x (33 bits for a-b)
        logic signed [32:0] py;
        logic signed [31:0] ox;      // offset added after rotation (not used for relative)
        logic signed [31:0] oy;
        logic signed [30:0] angle;   // wrapped result heading
    } item_t;

    // atan(2^-i) in Q4.28, rounded to nearest
    function automatic logic signed [31:0] atan_q28(input int i);
        logic signed [31:0] r;
        unique case (i)
            0:  r = 32'sd210828714;
            1:  r = 32'sd124459457;
            2:  r = 32'sd65760959;
            3:  r = 32'sd33381290;
            4:  r = 32'sd16755422;
            5:  r = 32'sd8385879;
            6:  r = 32'sd4193963;
            7:  r = 32'sd2097109;
            8:  r = 32'sd1048571;
            9:  r = 32'sd524287;
            10: r = 32'sd262144;
            11: r = 32'sd131072;
            12: r = 32'sd65536;
            13: r = 32'sd32768;
            14: r = 32'sd16384;
            15: r = 32'sd8192;
            16: r = 32'sd4096;
            17: r = 32'sd2048;
            18: r = 32'sd1024;
            19: r = 32'sd512;
            20: r = 32'sd256;
            21: r = 32'sd128;
            22: r = 32'sd64;
            23: r = 32'sd32;
            24: r = 32'sd16;
            25: r = 32'sd8;
            26: r = 32'sd4;
            27: r = 32'sd2;
            28: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/planar_rigid_pose_engine_top.sv
// pipeline: fold register, 24 cordic stages, multiply, sum
// throughput: one word per cycle unless stalled, set by the fully unrolled cordic pipeline
// the pipeline advances whenever the output register is empty or being taken
// a stalled output holds its word while in_ready drops; nothing is lost
// reset: asynchronous active low, clears all valid bits; pipeline data is not reset
// ----------------------------------------------------------------------------
// planar_rigid_pose_engine_top
// se(2) pose composition, relative pose and point transform in fixed point
// ----------------------------------------------------------------------------
module planar_rigid_pose_engine_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  a_x,
    input  logic signed [31:0]  a_y,
    input  logic signed [30:0]  a_angle,
    input  logic signed [31:0]  b_x,
    input  logic signed [31:0]  b_y,
    input  logic signed [30:0]  b_angle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  res_x,
    output logic signed [31:0]  res_y,
    output logic signed [30:0]  res_angle
);
    import prpe_pkg::*;

    // pipeline enable: the final register frees up or is empty
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // heading sum / difference with one wrap and clamp
    logic signed [32:0] asum;
    logic signed [32:0] awrap;
    logic signed [30:0] angle_w;
    always_comb
    begin
        if (cmd == CMD_RELATIVE)
            asum = 33'(a_angle) - 33'(b_angle);
        else
            asum = 33'(a_angle) + 33'(b_angle);
        awrap = asum;
        if (asum >= 33'(PiQ28))
            awrap = asum - 33'(TwoPiQ28);
        else if (asum < -33'(PiQ28))
            awrap = asum + 33'(TwoPiQ28);
        if (awrap > 33'(PiQ28) - 33'sd1)
            angle_w = 31'(PiQ28 - 32'sd1);
        else if (awrap < -33'(PiQ28))
            angle_w = 31'(-PiQ28);
        else
            angle_w = awrap[30:0];
    end

    // operand selection per command
    item_t              item_in;
    logic signed [30:0] rot_angle;
    always_comb
    begin
        item_in.cmd = cmd;
        if (cmd == CMD_RELATIVE)
        begin
            item_in.px  = 33'(a_x) - 33'(b_x);
            item_in.py  = 33'(a_y) - 33'(b_y);
            rot_angle   = b_angle;
        end
        else
        begin
            item_in.px  = 33'(b_x);
            item_in.py  = 33'(b_y);
            rot_angle   = a_angle;
        end
        item_in.ox    = a_x;
        item_in.oy    = a_y;
        item_in.angle = (cmd == CMD_COMPOSE || cmd == CMD_RELATIVE) ? angle_w : '0;
    end

    logic               c_valid;
    logic signed [31:0] c_cos, c_sin;
    item_t              c_item;

    prpe_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_angle  (rot_angle),
        .in_item   (item_in),
        .out_valid (c_valid),
        .out_cos   (c_cos),
        .out_sin   (c_sin),
        .out_item  (c_item)
    );

    // multiply, then sum with saturation; last register drives the outputs
    prpe_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid),
        .in_cos    (c_cos),
        .in_sin    (c_sin),
        .in_item   (c_item),
        .out_valid (out_valid),
        .out_x     (res_x),
        .out_y     (res_y),
        .out_angle (res_angle)
    );

`ifndef NO_ASSERTIONS
    // a stalled output word holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_x) && $stable(res_y)
            && $stable(res_angle))
        else $error("output word changed under stall");
    // ready follows the output register state
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready mismatch");
    // heading stays in [-pi, pi)
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(res_angle) < PiQ28) && (32'(res_angle) >= -PiQ28))
        else $error("heading out of range");
`endif
endmodule

### rtl/core/prpe_cordic.sv
// ----------------------------------------------------------------------------
// prpe_cordic
// unrolled rotation cordic, one register stage per iteration
// ----------------------------------------------------------------------------
module prpe_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [30:0]   in_angle,
    input  prpe_pkg::item_t      in_item,
    output logic                 out_valid,
    output logic signed [31:0]   out_cos,
    output logic signed [31:0]   out_sin,
    output prpe_pkg::item_t      out_item
);
    import prpe_pkg::*;

    localparam int N = CordicSteps;

    logic                valid_reg [N+1];
    logic signed [33:0]  x_reg     [N+1];
    logic signed [33:0]  y_reg     [N+1];
    logic signed [31:0]  z_reg     [N+1];
    logic                neg_reg   [N+1];
    item_t               item_reg  [N+1];

    // quadrant fold
    logic signed [31:0] z0_next;
    logic               neg0_next;
    always_comb
    begin
        z0_next   = 32'(in_angle);
        neg0_next = 1'b0;
        if (32'(in_angle) > HalfPiQ28)
        begin
            z0_next   = 32'(in_angle) - PiQ28;
            neg0_next = 1'b1;
        end
        else if (32'(in_angle) < -HalfPiQ28)
        begin
            z0_next   = 32'(in_angle) + PiQ28;
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= 34'(GainQ30);
            y_reg[0]    <= '0;
            z_reg[0]    <= z0_next;
            neg_reg[0]  <= neg0_next;
            item_reg[0] <= in_item;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic signed [33:0] x_next, y_next;
        logic signed [31:0] z_next;
        always_comb
        begin
            if (!z_reg[i][31])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_q28(i);
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_q28(i);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                neg_reg[i+1]  <= neg_reg[i];
                item_reg[i+1] <= item_reg[i];
            end
        end
    end

    // sign restore and clamp to [-1, 1]
    logic signed [33:0] xf, yf;
    assign xf = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign yf = neg_reg[N] ? -y_reg[N] : y_reg[N];

    assign out_valid = valid_reg[N];
    assign out_item  = item_reg[N];
    assign out_cos   = (xf > 34'(OneQ30)) ? OneQ30 :
                       (xf < -34'(OneQ30)) ? -OneQ30 : xf[31:0];
    assign out_sin   = (yf > 34'(OneQ30)) ? OneQ30 :
                       (yf < -34'(OneQ30)) ? -OneQ30 : yf[31:0];
endmodule

### rtl/core/prpe_rotate.sv
// ----------------------------------------------------------------------------
// prpe_rotate
// multiply stage, rounded products, then sum and saturate stage
// ----------------------------------------------------------------------------
module prpe_rotate (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [31:0]   in_cos,
    input  logic signed [31:0]   in_sin,
    input  prpe_pkg::item_t      in_item,
    output logic                 out_valid,
    output logic signed [31:0]   out_x,
    output logic signed [31:0]   out_y,
    output logic signed [30:0]   out_angle
);
    import prpe_pkg::*;

    logic               m_valid_reg;
    logic signed [35:0] pxc_reg, pxs_reg, pyc_reg, pys_reg;
    item_t              m_item_reg;

    function automatic logic signed [35:0] mulr(input logic signed [32:0] p,
                                                input logic signed [31:0] f);
        logic signed [65:0] prod;
        logic signed [65:0] rnd;
        prod = 66'(p) * 66'(f);
        rnd  = prod + 66'sd536870912;
        return rnd[65:30];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxc_reg    <= mulr(in_item.px, in_cos);
            pxs_reg    <= mulr(in_item.px, in_sin);
            pyc_reg    <= mulr(in_item.py, in_cos);
            pys_reg    <= mulr(in_item.py, in_sin);
            m_item_reg <= in_item;
        end
    end

    logic signed [37:0] sx, sy;
    always_comb
    begin
        if (m_item_reg.cmd == CMD_RELATIVE)
        begin
            sx = 38'(pxc_reg) + 38'(pys_reg);
            sy = 38'(pyc_reg) - 38'(pxs_reg);
        end
        else
        begin
            sx = 38'(m_item_reg.ox) + 38'(pxc_reg) - 38'(pys_reg);
            sy = 38'(m_item_reg.oy) + 38'(pxs_reg) + 38'(pyc_reg);
        end
    end

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -38'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    logic               o_valid_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [30:0] a_reg;
    logic               none;
    assign none = (m_item_reg.cmd == CMD_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= none ? '0 : sat32(sx);
            y_reg <= none ? '0 : sat32(sy);
            a_reg <= m_item_reg.angle;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_angle = a_reg;
endmodule
